/* rtl/time_of_day_plan_selector_unit_assert.svh */
// Assertion macros used by the time-of-day plan selector checker.
`ifndef TIME_OF_DAY_PLAN_SELECTOR_UNIT_ASSERT_SVH
`define TIME_OF_DAY_PLAN_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TODPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TODPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/todps_pkg.sv */
// Types, constants and helper functions of the time-of-day plan selector.
`default_nettype none

package todps_pkg;

  localparam int unsigned ScheduleEntriesDef  = 64;
  localparam int unsigned SegmentTablesDef    = 16;
  localparam int unsigned SegmentsPerTableDef = 64;

  localparam int unsigned MinPerHour = 60;
  localparam int unsigned TimeW      = 11;  // 31*60+63 fits

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_SCHED = 2'd1,
    OP_SEG   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCHED,
    ST_SEG,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [12:0] month_mask;
    logic [31:0] day_mask;
    logic [7:0]  week_mask;
    logic [4:0]  table_id;
  } sched_entry_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [7:0] action;
  } seg_entry_t;

  // Month bit and (day bit or weekday bit); bits past a mask read as zero.
  function automatic logic sched_match(sched_entry_t e, logic [3:0] month,
                                       logic [4:0] day, logic [2:0] weekday);
    logic [15:0] mm;
    logic [15:0] wm;
    logic [3:0]  wpos;
    mm   = 16'(e.month_mask);
    wm   = 16'(e.week_mask);
    wpos = 4'(weekday) + 4'd1;
    return mm[month] & (e.day_mask[day] | wm[wpos]);
  endfunction

  function automatic logic [TimeW-1:0] to_minutes(logic [4:0] hour, logic [5:0] minute);
    return TimeW'(hour) * TimeW'(MinPerHour) + TimeW'(minute);
  endfunction

endpackage

`default_nettype wire

/* rtl/time_of_day_plan_selector_unit.sv */
// Flow: a write or an idle opcode goes straight to ST_DONE and raises its word once the
// output register is free; a query walks the schedule, then a valid matched table's segments.
// Throughput: one item at a time, as in_ready_o is high only in ST_IDLE; the walk reads one
// schedule entry, then one segment, per cycle.
// Reset: rst_ni clears control state, then a clearing pass over max(SCHEDULE_ENTRIES,
// SEGMENT_TABLES*SEGMENTS_PER_TABLE) addresses (1024 default) runs before the first item.
`default_nettype none

module time_of_day_plan_selector_unit #(
  parameter int unsigned SCHEDULE_ENTRIES   = todps_pkg::ScheduleEntriesDef,
  parameter int unsigned SEGMENT_TABLES     = todps_pkg::SegmentTablesDef,
  parameter int unsigned SEGMENTS_PER_TABLE = todps_pkg::SegmentsPerTableDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [6:0]  entry_id_i,
  input  wire logic [4:0]  table_id_i,
  input  wire logic [12:0] month_mask_i,
  input  wire logic [31:0] day_mask_i,
  input  wire logic [7:0]  week_mask_i,
  input  wire logic [4:0]  hour_i,
  input  wire logic [5:0]  minute_i,
  input  wire logic [7:0]  action_id_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [4:0]  day_i,
  input  wire logic [2:0]  weekday_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       selected_action_o,
  output logic [4:0]       selected_table_o,
  output logic             found_o
);

  localparam int unsigned SegDepth = SEGMENT_TABLES * SEGMENTS_PER_TABLE;
  localparam int unsigned SchAw    = (SCHEDULE_ENTRIES > 1) ? $clog2(SCHEDULE_ENTRIES) : 1;
  localparam int unsigned SegAw    = (SegDepth > 1) ? $clog2(SegDepth) : 1;

  logic                    sch_we;
  logic [SchAw-1:0]        sch_waddr;
  todps_pkg::sched_entry_t sch_wdata;
  logic [SchAw-1:0]        sch_raddr;
  todps_pkg::sched_entry_t sch_rdata;
  logic                    seg_we;
  logic [SegAw-1:0]        seg_waddr;
  todps_pkg::seg_entry_t   seg_wdata;
  logic [SegAw-1:0]        seg_raddr;
  todps_pkg::seg_entry_t   seg_rdata;

  todps_ram #(
    .Width($bits(todps_pkg::sched_entry_t)),
    .Depth(SCHEDULE_ENTRIES),
    .AddrW(SchAw)
  ) u_sched_ram (
    .clk_i   (clk_i),
    .we_i    (sch_we),
    .waddr_i (sch_waddr),
    .wdata_i (sch_wdata),
    .raddr_i (sch_raddr),
    .rdata_o (sch_rdata)
  );

  todps_ram #(
    .Width($bits(todps_pkg::seg_entry_t)),
    .Depth(SegDepth),
    .AddrW(SegAw)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_waddr),
    .wdata_i (seg_wdata),
    .raddr_i (seg_raddr),
    .rdata_o (seg_rdata)
  );

  todps_ctrl #(
    .SCHEDULE_ENTRIES   (SCHEDULE_ENTRIES),
    .SEGMENT_TABLES     (SEGMENT_TABLES),
    .SEGMENTS_PER_TABLE (SEGMENTS_PER_TABLE),
    .SchAw              (SchAw),
    .SegAw              (SegAw)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .entry_id_i        (entry_id_i),
    .table_id_i        (table_id_i),
    .month_mask_i      (month_mask_i),
    .day_mask_i        (day_mask_i),
    .week_mask_i       (week_mask_i),
    .hour_i            (hour_i),
    .minute_i          (minute_i),
    .action_id_i       (action_id_i),
    .month_i           (month_i),
    .day_i             (day_i),
    .weekday_i         (weekday_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .selected_action_o (selected_action_o),
    .selected_table_o  (selected_table_o),
    .found_o           (found_o),
    .sch_we_o          (sch_we),
    .sch_waddr_o       (sch_waddr),
    .sch_wdata_o       (sch_wdata),
    .sch_raddr_o       (sch_raddr),
    .sch_rdata_i       (sch_rdata),
    .seg_we_o          (seg_we),
    .seg_waddr_o       (seg_waddr),
    .seg_wdata_o       (seg_wdata),
    .seg_raddr_o       (seg_raddr),
    .seg_rdata_i       (seg_rdata)
  );

endmodule

`default_nettype wire

/* rtl/todps_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module todps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/todps_ctrl.sv */
// Sequencer: clearing pass, memory writes, schedule walk and segment walk.
`default_nettype none

module todps_ctrl #(
  parameter int unsigned SCHEDULE_ENTRIES   = todps_pkg::ScheduleEntriesDef,
  parameter int unsigned SEGMENT_TABLES     = todps_pkg::SegmentTablesDef,
  parameter int unsigned SEGMENTS_PER_TABLE = todps_pkg::SegmentsPerTableDef,
  parameter int unsigned SchAw = (SCHEDULE_ENTRIES > 1) ? $clog2(SCHEDULE_ENTRIES) : 1,
  parameter int unsigned SegAw = (SEGMENT_TABLES * SEGMENTS_PER_TABLE > 1) ?
                                 $clog2(SEGMENT_TABLES * SEGMENTS_PER_TABLE) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                opcode_i,
  input  wire logic [6:0]                entry_id_i,
  input  wire logic [4:0]                table_id_i,
  input  wire logic [12:0]               month_mask_i,
  input  wire logic [31:0]               day_mask_i,
  input  wire logic [7:0]                week_mask_i,
  input  wire logic [4:0]                hour_i,
  input  wire logic [5:0]                minute_i,
  input  wire logic [7:0]                action_id_i,
  input  wire logic [3:0]                month_i,
  input  wire logic [4:0]                day_i,
  input  wire logic [2:0]                weekday_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [7:0]                     selected_action_o,
  output logic [4:0]                     selected_table_o,
  output logic                           found_o,
  output logic                           sch_we_o,
  output logic [SchAw-1:0]               sch_waddr_o,
  output todps_pkg::sched_entry_t        sch_wdata_o,
  output logic [SchAw-1:0]               sch_raddr_o,
  input  todps_pkg::sched_entry_t        sch_rdata_i,
  output logic                           seg_we_o,
  output logic [SegAw-1:0]               seg_waddr_o,
  output todps_pkg::seg_entry_t          seg_wdata_o,
  output logic [SegAw-1:0]               seg_raddr_o,
  input  todps_pkg::seg_entry_t          seg_rdata_i
);

  localparam int unsigned SegDepth = SEGMENT_TABLES * SEGMENTS_PER_TABLE;
  localparam int unsigned ClrDepth = (SegDepth > SCHEDULE_ENTRIES) ? SegDepth
                                                                   : SCHEDULE_ENTRIES;
  localparam int unsigned ClrCw = $clog2(ClrDepth + 1);
  localparam int unsigned SchCw = $clog2(SCHEDULE_ENTRIES + 1);
  localparam int unsigned SegCw = $clog2(SEGMENTS_PER_TABLE + 1);
  localparam int unsigned TW    = todps_pkg::TimeW;

  todps_pkg::state_e state_q, state_d;

  logic [ClrCw-1:0] clr_q, clr_d;
  logic [SchCw-1:0] sch_cnt_q, sch_cnt_d;
  logic [SegCw-1:0] seg_cnt_q, seg_cnt_d;
  logic [3:0]       month_q, month_d;
  logic [4:0]       day_q, day_d;
  logic [2:0]       weekday_q, weekday_d;
  logic [TW-1:0]    now_q, now_d;
  logic [SegAw-1:0] base_q, base_d;
  logic             have_before_q, have_before_d;
  logic [TW-1:0]    before_t_q, before_t_d;
  logic [7:0]       before_act_q, before_act_d;
  logic             have_any_q, have_any_d;
  logic [TW-1:0]    any_t_q, any_t_d;
  logic [7:0]       any_act_q, any_act_d;
  logic [7:0]       res_act_q, res_act_d;
  logic [4:0]       res_tbl_q, res_tbl_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_act_q, out_act_d;
  logic [4:0]       out_tbl_q, out_tbl_d;

  logic             exact_hit;
  logic [TW-1:0]    seg_t;
  logic [4:0]       tbl_m1;

  assign sch_raddr_o = SchAw'(sch_cnt_q);
  assign seg_raddr_o = base_q + SegAw'(seg_cnt_q);
  assign seg_t       = todps_pkg::to_minutes(seg_rdata_i.hour, seg_rdata_i.minute);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    sch_cnt_d     = sch_cnt_q;
    seg_cnt_d     = seg_cnt_q;
    month_d       = month_q;
    day_d         = day_q;
    weekday_d     = weekday_q;
    now_d         = now_q;
    base_d        = base_q;
    have_before_d = have_before_q;
    before_t_d    = before_t_q;
    before_act_d  = before_act_q;
    have_any_d    = have_any_q;
    any_t_d       = any_t_q;
    any_act_d     = any_act_q;
    res_act_d     = res_act_q;
    res_tbl_d     = res_tbl_q;
    out_valid_d   = out_valid_q;
    out_act_d     = out_act_q;
    out_tbl_d     = out_tbl_q;
    in_ready_o    = 1'b0;
    sch_we_o      = 1'b0;
    sch_waddr_o   = SchAw'(entry_id_i - 7'd1);
    sch_wdata_o   = '{month_mask: month_mask_i, day_mask: day_mask_i,
                      week_mask: week_mask_i, table_id: table_id_i};
    seg_we_o      = 1'b0;
    seg_waddr_o   = SegAw'(32'(table_id_i - 5'd1) * 32'(SEGMENTS_PER_TABLE)) +
                    SegAw'(entry_id_i - 7'd1);
    seg_wdata_o   = '{hour: hour_i, minute: minute_i, action: action_id_i};
    exact_hit     = 1'b0;
    tbl_m1        = sch_rdata_i.table_id - 5'd1;

    // drop the output word once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      todps_pkg::ST_CLEAR: begin
        sch_we_o    = 32'(clr_q) < SCHEDULE_ENTRIES;
        sch_waddr_o = SchAw'(clr_q);
        sch_wdata_o = '0;
        seg_we_o    = 32'(clr_q) < SegDepth;
        seg_waddr_o = SegAw'(clr_q);
        seg_wdata_o = '0;
        clr_d       = clr_q + ClrCw'(1);
        if (32'(clr_q) == ClrDepth - 1) begin
          state_d = todps_pkg::ST_IDLE;
        end
      end
      todps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          month_d       = month_i;
          day_d         = day_i;
          weekday_d     = weekday_i;
          now_d         = todps_pkg::to_minutes(hour_i, minute_i);
          sch_cnt_d     = '0;
          seg_cnt_d     = '0;
          have_before_d = 1'b0;
          have_any_d    = 1'b0;
          res_act_d     = '0;
          res_tbl_d     = '0;
          state_d       = todps_pkg::ST_DONE;
          case (todps_pkg::opcode_e'(opcode_i))
            todps_pkg::OP_QUERY: begin
              state_d = todps_pkg::ST_SCHED;
            end
            todps_pkg::OP_SCHED: begin
              sch_we_o = (entry_id_i != 7'd0) && (32'(entry_id_i) <= SCHEDULE_ENTRIES);
            end
            todps_pkg::OP_SEG: begin
              seg_we_o = (entry_id_i != 7'd0) && (32'(entry_id_i) <= SEGMENTS_PER_TABLE) &&
                         (table_id_i != 5'd0) && (32'(table_id_i) <= SEGMENT_TABLES);
            end
            default: begin
            end
          endcase
        end
      end
      todps_pkg::ST_SCHED: begin
        // read data belongs to the entry addressed in the cycle before
        if (sch_cnt_q != '0 &&
            todps_pkg::sched_match(sch_rdata_i, month_q, day_q, weekday_q)) begin
          res_tbl_d = sch_rdata_i.table_id;
          if (sch_rdata_i.table_id != 5'd0 &&
              32'(sch_rdata_i.table_id) <= SEGMENT_TABLES) begin
            base_d  = SegAw'(32'(tbl_m1) * 32'(SEGMENTS_PER_TABLE));
            state_d = todps_pkg::ST_SEG;
          end else begin
            state_d = todps_pkg::ST_DONE;
          end
        end else if (32'(sch_cnt_q) == SCHEDULE_ENTRIES) begin
          state_d = todps_pkg::ST_DONE;
        end else begin
          sch_cnt_d = sch_cnt_q + SchCw'(1);
        end
      end
      todps_pkg::ST_SEG: begin
        if (seg_cnt_q != '0 && seg_rdata_i.action != 8'd0) begin
          if (seg_t == now_q) begin
            exact_hit = 1'b1;
          end else begin
            if (seg_t < now_q && (!have_before_q || seg_t > before_t_q)) begin
              have_before_d = 1'b1;
              before_t_d    = seg_t;
              before_act_d  = seg_rdata_i.action;
            end
            if (!have_any_q || seg_t > any_t_q) begin
              have_any_d = 1'b1;
              any_t_d    = seg_t;
              any_act_d  = seg_rdata_i.action;
            end
          end
        end
        if (exact_hit) begin
          res_act_d = seg_rdata_i.action;
          state_d   = todps_pkg::ST_DONE;
        end else if (32'(seg_cnt_q) == SEGMENTS_PER_TABLE) begin
          res_act_d = have_before_d ? before_act_d :
                      have_any_d    ? any_act_d    : 8'd0;
          state_d   = todps_pkg::ST_DONE;
        end else begin
          seg_cnt_d = seg_cnt_q + SegCw'(1);
        end
      end
      todps_pkg::ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_act_d   = res_act_q;
          out_tbl_d   = res_tbl_q;
          state_d     = todps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = todps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= todps_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sch_cnt_q     <= sch_cnt_d;
    seg_cnt_q     <= seg_cnt_d;
    month_q       <= month_d;
    day_q         <= day_d;
    weekday_q     <= weekday_d;
    now_q         <= now_d;
    base_q        <= base_d;
    have_before_q <= have_before_d;
    before_t_q    <= before_t_d;
    before_act_q  <= before_act_d;
    have_any_q    <= have_any_d;
    any_t_q       <= any_t_d;
    any_act_q     <= any_act_d;
    res_act_q     <= res_act_d;
    res_tbl_q     <= res_tbl_d;
    out_act_q     <= out_act_d;
    out_tbl_q     <= out_tbl_d;
  end

  assign out_valid_o       = out_valid_q;
  assign selected_action_o = out_act_q;
  assign selected_table_o  = out_tbl_q;
  assign found_o           = |out_act_q;

endmodule

`default_nettype wire

/* rtl/todps_checker.sv */
// Port-level checker for the time-of-day plan selector, bound to the top level.
`default_nettype none

`include "time_of_day_plan_selector_unit_assert.svh"

module todps_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] selected_action_o,
  input wire logic [4:0] selected_table_o,
  input wire logic       found_o
);

  `TODPS_ASSERT_NOW(a_found_matches_action, out_valid_o, found_o == (selected_action_o != 8'd0), "found disagrees with selected action")
  `TODPS_ASSERT_NOW(a_action_needs_table, out_valid_o && found_o, selected_table_o != 5'd0, "action reported without a table")
  `TODPS_ASSERT_NEXT(a_one_item_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "second word taken while one is at work")
  `TODPS_ASSERT_NEXT(a_stalled_word_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(selected_action_o) && $stable(selected_table_o), "stalled output word changed")

endmodule

bind time_of_day_plan_selector_unit todps_checker u_todps_checker (.*);

`default_nettype wire

/* tb/sv/todps_tb_pkg.sv */
// Word types and shadow-table scoreboard for the time-of-day plan selector bench.
package todps_tb_pkg;
  import todps_pkg::*;

  localparam int unsigned NumSched     = ScheduleEntriesDef;
  localparam int unsigned NumTables    = SegmentTablesDef;
  localparam int unsigned SegsPerTable = SegmentsPerTableDef;
  localparam logic [1:0]  OpIdle       = 2'd3;
  localparam int unsigned MaxReported  = 10;

  typedef struct {
    logic [1:0]  opcode;
    logic [6:0]  entry_id;
    logic [4:0]  table_id;
    logic [12:0] month_mask;
    logic [31:0] day_mask;
    logic [7:0]  week_mask;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  action_id;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
  } plan_cmd_t;

  typedef struct {
    logic [7:0] action;
    logic [4:0] table_id;
    logic       found;
  } plan_result_t;

  class plan_scoreboard;
    sched_entry_t sched_mem [NumSched];
    seg_entry_t   seg_mem   [NumTables * SegsPerTable];
    plan_result_t want_q [$];
    int unsigned  mismatches;

    function new();
      foreach (sched_mem[i]) sched_mem[i] = '0;
      foreach (seg_mem[i]) seg_mem[i] = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted word to the shadow tables and queue the result it must give.
    function void note_word(plan_cmd_t c);
      plan_result_t r;
      sched_entry_t e;
      seg_entry_t   s;
      int unsigned  i, base, now, t, wpos, before_t, any_t;
      logic [7:0]   before_act, any_act;
      bit           have_before, have_any, exact;
      r.action   = '0;
      r.table_id = '0;
      r.found    = 1'b0;
      case (c.opcode)
        OP_SCHED: begin
          if (c.entry_id >= 1 && c.entry_id <= NumSched) begin
            e.month_mask = c.month_mask;
            e.day_mask   = c.day_mask;
            e.week_mask  = c.week_mask;
            e.table_id   = c.table_id;
            sched_mem[int'(c.entry_id) - 1] = e;
          end
        end
        OP_SEG: begin
          if (c.entry_id >= 1 && c.entry_id <= SegsPerTable &&
              c.table_id >= 1 && c.table_id <= NumTables) begin
            s.hour   = c.hour;
            s.minute = c.minute;
            s.action = c.action_id;
            seg_mem[(int'(c.table_id) - 1) * SegsPerTable + int'(c.entry_id) - 1] = s;
          end
        end
        OP_QUERY: begin
          wpos = int'(c.weekday) + 1;
          // first matching entry ends the scan, whatever table it names
          for (i = 0; i < NumSched; i++) begin
            e = sched_mem[i];
            if (((32'(e.month_mask) >> c.month) & 32'd1) != 0 &&
                (((e.day_mask >> c.day) & 32'd1) != 0 ||
                 ((32'(e.week_mask) >> wpos) & 32'd1) != 0)) begin
              r.table_id = e.table_id;
              break;
            end
          end
          if (r.table_id >= 1 && r.table_id <= NumTables) begin
            base        = (int'(r.table_id) - 1) * SegsPerTable;
            now         = int'(c.hour) * MinPerHour + int'(c.minute);
            exact       = 1'b0;
            have_before = 1'b0;
            have_any    = 1'b0;
            before_t    = 0;
            any_t       = 0;
            before_act  = '0;
            any_act     = '0;
            for (i = 0; i < SegsPerTable && !exact; i++) begin
              s = seg_mem[base + i];
              if (s.action != 0) begin
                t = int'(s.hour) * MinPerHour + int'(s.minute);
                if (t == now) begin
                  r.action = s.action;
                  exact    = 1'b1;
                end else begin
                  // strict compares keep the lowest index on ties
                  if (t < now && (!have_before || t > before_t)) begin
                    have_before = 1'b1;
                    before_t    = t;
                    before_act  = s.action;
                  end
                  if (!have_any || t > any_t) begin
                    have_any = 1'b1;
                    any_t    = t;
                    any_act  = s.action;
                  end
                end
              end
            end
            // else take the latest start before now, failing that the latest start of the previous day
            if (!exact) r.action = have_before ? before_act : (have_any ? any_act : 8'd0);
          end
          r.found = (r.action != 0);
        end
        default: begin
        end
      endcase
      want_q.push_back(r);
    endfunction

    function void check_word(plan_result_t got);
      plan_result_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected word: action %0d table %0d found %0b",
                   got.action, got.table_id, got.found);
        return;
      end
      want = want_q.pop_front();
      if (got.action !== want.action || got.table_id !== want.table_id ||
          got.found !== want.found) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("mismatch: expected action %0d table %0d found %0b, got action %0d table %0d found %0b",
                   want.action, want.table_id, want.found,
                   got.action, got.table_id, got.found);
      end
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction
  endclass

endpackage

/* tb/sv/tb_time_of_day_plan_selector_unit.sv */
// Bench top for the time-of-day plan selector: clock, reset, drivers, receiver and verdict.
module tb_time_of_day_plan_selector_unit;
  import todps_pkg::*;
  import todps_tb_pkg::*;

  localparam int unsigned QueryLatency  = NumSched + SegsPerTable + 3;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned MaxGap        = 18;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned PhaseWords    = 100;
  localparam int unsigned NumPhases     = 7;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i     = '0;
  logic [6:0]  entry_id_i   = '0;
  logic [4:0]  table_id_i   = '0;
  logic [12:0] month_mask_i = '0;
  logic [31:0] day_mask_i   = '0;
  logic [7:0]  week_mask_i  = '0;
  logic [4:0]  hour_i       = '0;
  logic [5:0]  minute_i     = '0;
  logic [7:0]  action_id_i  = '0;
  logic [3:0]  month_i      = '0;
  logic [4:0]  day_i        = '0;
  logic [2:0]  weekday_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [7:0]  selected_action_o;
  logic [4:0]  selected_table_o;
  logic        found_o;

  plan_scoreboard plan_sb = new();

  bit          send_idle    = 1'b1;
  bit          recv_idle    = 1'b1;
  bit          hold_req     = 1'b0;
  int unsigned quiet_cycles = 0;

  time_of_day_plan_selector_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .entry_id_i        (entry_id_i),
    .table_id_i        (table_id_i),
    .month_mask_i      (month_mask_i),
    .day_mask_i        (day_mask_i),
    .week_mask_i       (week_mask_i),
    .hour_i            (hour_i),
    .minute_i          (minute_i),
    .action_id_i       (action_id_i),
    .month_i           (month_i),
    .day_i             (day_i),
    .weekday_i         (weekday_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .selected_action_o (selected_action_o),
    .selected_table_o  (selected_table_o),
    .found_o           (found_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic plan_cmd_t noise_cmd();
    plan_cmd_t c;
    c.opcode     = 2'($urandom);
    c.entry_id   = 7'($urandom);
    c.table_id   = 5'($urandom);
    c.month_mask = 13'($urandom);
    c.day_mask   = $urandom;
    c.week_mask  = 8'($urandom);
    c.hour       = 5'($urandom);
    c.minute     = 6'($urandom);
    c.action_id  = 8'($urandom);
    c.month      = 4'($urandom);
    c.day        = 5'($urandom);
    c.weekday    = 3'($urandom);
    return c;
  endfunction

  function automatic plan_cmd_t sched_cmd(logic [6:0] entry, logic [4:0] tbl,
                                          logic [12:0] mm, logic [31:0] dm, logic [7:0] wm);
    plan_cmd_t c;
    c            = noise_cmd();
    c.opcode     = OP_SCHED;
    c.entry_id   = entry;
    c.table_id   = tbl;
    c.month_mask = mm;
    c.day_mask   = dm;
    c.week_mask  = wm;
    return c;
  endfunction

  function automatic plan_cmd_t seg_cmd(logic [6:0] entry, logic [4:0] tbl,
                                        logic [4:0] hr, logic [5:0] mnt, logic [7:0] act);
    plan_cmd_t c;
    c           = noise_cmd();
    c.opcode    = OP_SEG;
    c.entry_id  = entry;
    c.table_id  = tbl;
    c.hour      = hr;
    c.minute    = mnt;
    c.action_id = act;
    return c;
  endfunction

  function automatic plan_cmd_t query_cmd(logic [3:0] mon, logic [4:0] dy, logic [2:0] wd,
                                          logic [4:0] hr, logic [5:0] mnt);
    plan_cmd_t c;
    c         = noise_cmd();
    c.opcode  = OP_QUERY;
    c.month   = mon;
    c.day     = dy;
    c.weekday = wd;
    c.hour    = hr;
    c.minute  = mnt;
    return c;
  endfunction

  // Mostly well-formed words; sparse masks push the first match deep into the schedule.
  function automatic plan_cmd_t random_cmd();
    int unsigned pick;
    logic [4:0]  tbl;
    logic [5:0]  mnt;
    pick = $urandom_range(0, 99);
    tbl  = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(1, 4))
                                       : 5'($urandom_range(1, NumTables));
    // quarter-hour starts make exact matches common
    mnt  = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 59))
                                       : 6'(15 * $urandom_range(0, 3));
    if (pick < 35)
      return query_cmd(4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
                       3'($urandom_range(0, 6)), 5'($urandom_range(0, 23)), mnt);
    if (pick < 55) begin
      if ($urandom_range(0, 15) == 0) tbl = 5'($urandom);
      return sched_cmd(7'($urandom_range(1, NumSched)), tbl, 13'($urandom & $urandom),
                       $urandom & $urandom & $urandom, 8'($urandom & $urandom));
    end
    if (pick < 85)
      return seg_cmd(7'($urandom_range(1, SegsPerTable)), tbl, 5'($urandom_range(0, 23)), mnt,
                     ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
    return noise_cmd();
  endfunction

  // Hold valid across back-to-back words; drop it only when a gap is drawn.
  task automatic send_cmd(input plan_cmd_t c);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode_i     <= c.opcode;
    entry_id_i   <= c.entry_id;
    table_id_i   <= c.table_id;
    month_mask_i <= c.month_mask;
    day_mask_i   <= c.day_mask;
    week_mask_i  <= c.week_mask;
    hour_i       <= c.hour;
    minute_i     <= c.minute;
    action_id_i  <= c.action_id;
    month_i      <= c.month;
    day_i        <= c.day;
    weekday_i    <= c.weekday;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    plan_sb.note_word(c);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (plan_sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned  stall;
    plan_result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      stall = recv_idle ? $urandom_range(0, MaxGap) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.action   = selected_action_o;
      got.table_id = selected_table_o;
      got.found    = found_o;
      plan_sb.check_word(got);
    end
  end

  initial begin : stimulus
    plan_cmd_t   c;
    int unsigned phase, n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(query_cmd(4'd1, 5'd1, 3'd0, 5'd0, 6'd0));
    // writes that must be dropped, then a valid write to the last schedule entry
    send_cmd(sched_cmd(7'd0, 5'd16, 13'h1FFF, 32'hFFFF_FFFF, 8'hFF));
    send_cmd(seg_cmd(7'd0, 5'd16, 5'd8, 6'd0, 8'd10));
    send_cmd(seg_cmd(7'd65, 5'd16, 5'd8, 6'd0, 8'd10));
    send_cmd(seg_cmd(7'd1, 5'd0, 5'd8, 6'd0, 8'd10));
    send_cmd(seg_cmd(7'd1, 5'd17, 5'd8, 6'd0, 8'd10));
    send_cmd(sched_cmd(7'd64, 5'd16, 13'h1FFF, 32'hFFFF_FFFF, 8'hFF));
    // table with no used segment
    send_cmd(query_cmd(4'd6, 5'd15, 3'd3, 5'd8, 6'd0));
    send_cmd(seg_cmd(7'd1, 5'd16, 5'd8, 6'd0, 8'd10));
    send_cmd(seg_cmd(7'd2, 5'd16, 5'd8, 6'd0, 8'd11));
    send_cmd(seg_cmd(7'd3, 5'd16, 5'd12, 6'd0, 8'd0));
    send_cmd(seg_cmd(7'd64, 5'd16, 5'd20, 6'd30, 8'd255));
    // exact, latest before, previous day, unused skipped, beyond 23:59
    send_cmd(query_cmd(4'd3, 5'd9, 3'd1, 5'd8, 6'd0));
    send_cmd(query_cmd(4'd3, 5'd9, 3'd1, 5'd10, 6'd0));
    send_cmd(query_cmd(4'd3, 5'd9, 3'd1, 5'd7, 6'd0));
    send_cmd(query_cmd(4'd3, 5'd9, 3'd1, 5'd12, 6'd0));
    send_cmd(query_cmd(4'd3, 5'd9, 3'd1, 5'd20, 6'd30));
    send_cmd(query_cmd(4'd3, 5'd9, 3'd1, 5'd31, 6'd63));
    // first match names table zero, weekday-only match names an absent table
    send_cmd(sched_cmd(7'd1, 5'd0, 13'h1000, 32'h8000_0000, 8'h00));
    send_cmd(query_cmd(4'd12, 5'd31, 3'd0, 5'd8, 6'd0));
    send_cmd(sched_cmd(7'd2, 5'd20, 13'h0002, 32'h0000_0000, 8'h80));
    send_cmd(query_cmd(4'd1, 5'd5, 3'd6, 5'd8, 6'd0));
    // mask positions past the stored width
    send_cmd(query_cmd(4'd13, 5'd0, 3'd7, 5'd8, 6'd0));
    send_cmd(query_cmd(4'd0, 5'd0, 3'd7, 5'd8, 6'd0));
    c        = noise_cmd();
    c.opcode = OpIdle;
    send_cmd(c);
    wait_drained();

    for (phase = 0; phase < NumPhases; phase++) begin
      send_idle = (phase % 3) != 1;
      recv_idle = (phase % 3) != 1;
      if (phase == 2) begin
        // stall the output side while words keep coming
        send_idle = 1'b0;
        hold_req  = 1'b1;
      end
      for (n = 0; n < PhaseWords; n++) send_cmd(random_cmd());
      wait_drained();
    end

    repeat (QueryLatency + MaxGap) @(posedge clk_i);
    if (plan_sb.mismatches == 0 && plan_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/todps_pkg.sv
rtl/todps_ram.sv
rtl/todps_ctrl.sv
rtl/time_of_day_plan_selector_unit.sv
rtl/todps_checker.sv
tb/sv/todps_tb_pkg.sv
tb/sv/tb_time_of_day_plan_selector_unit.sv
